FILE: rtl/wrc_pkg.sv
// Shared types and constants for the windowed request rate counter.
`default_nettype none

package wrc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned BYTE_W = 64;
    localparam int unsigned ADDR_W = 3;

    localparam logic [DATA_W-1:0] WINDOW_LENGTH_RESET = 32'd60;

    // Register word index decoded from paddr[ADDR_W-1:2].
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ACCUM  = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

FILE: rtl/wrc_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module wrc_divider (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire  [wrc_pkg::DATA_W-1:0]   dividend,
    input  wire  [wrc_pkg::DATA_W-1:0]   divisor,
    output wrc_pkg::div_status_t         status,
    output logic [wrc_pkg::DATA_W-1:0]   quotient,
    output logic [wrc_pkg::DATA_W-1:0]   remainder
);

    localparam int unsigned W     = wrc_pkg::DATA_W;
    localparam int unsigned CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(W - 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     divisor_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [W:0]   shifted;
    logic [W-1:0] diff;
    logic         fits;

    // where the divisor fits, the true difference is below the divisor
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted[W-1:0] - divisor_reg;
    assign fits    = shifted >= {1'b0, divisor_reg};

    always_comb begin
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = done_reg;
        if (start) begin
            rem_next   = '0;
            quo_next   = dividend;
            count_next = STEP_LAST;
            busy_next  = 1'b1;
            done_next  = 1'b0;
        end else if (busy_reg) begin
            // shift in the next dividend bit, subtract where the divisor fits
            rem_next   = fits ? diff : shifted[W-1:0];
            quo_next   = {quo_reg[W-2:0], fits};
            count_next = count_reg - CNT_W'(1);
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            divisor_reg <= divisor;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule

`default_nettype wire

FILE: rtl/windowed_request_rate_counter_top.sv
// Top level of the windowed request rate counter: sequencer, totals and register port.
`default_nettype none

// Counts cache requests in tumbling windows of window_length timestamp units
// (a length of 0 acts as 1). A request is accepted on an s_ beat, captured,
// and then in the accumulate step added to the saturating totals while its
// timestamp is compared with the window boundary. When the request reaches the
// boundary, the number of empty windows skipped is found by a bit-serial
// divider that produces one quotient bit per cycle, and s_ready stays low
// until the division is done and the result is issued, which waits while the
// previous result beat is still waiting on m_ready. One m_ beat then carries the
// closed window's totals, the totals clear, and the boundary moves to the first
// window end past the request. window_length sits at byte address 0 of the APB
// port and should be written only while the block is idle.
module windowed_request_rate_counter_top (
    input  wire                          aclk,
    input  wire                          aresetn,

    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [wrc_pkg::ADDR_W-1:0]   paddr,
    input  wire  [wrc_pkg::DATA_W-1:0]   pwdata,
    output logic [wrc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,

    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [wrc_pkg::DATA_W-1:0]   s_timestamp,
    input  wire  [wrc_pkg::DATA_W-1:0]   s_object_size,
    input  wire                          s_first_in_window,
    input  wire                          s_compulsory_miss,

    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [wrc_pkg::DATA_W-1:0]   m_window_requests,
    output logic [wrc_pkg::BYTE_W-1:0]   m_window_bytes,
    output logic [wrc_pkg::DATA_W-1:0]   m_window_objects,
    output logic [wrc_pkg::DATA_W-1:0]   m_window_cold_misses,
    output logic [wrc_pkg::DATA_W-1:0]   m_empty_windows_after
);

    localparam int unsigned W  = wrc_pkg::DATA_W;
    localparam int unsigned BW = wrc_pkg::BYTE_W;

    // register port
    logic [W-1:0] window_length_reg;
    logic         cfg_write;
    logic         cfg_sel_len;

    assign pready      = 1'b1;
    assign cfg_sel_len = paddr[wrc_pkg::ADDR_W-1] == wrc_pkg::REG_WINDOW_LENGTH;
    assign cfg_write   = psel && penable && pwrite && pready;
    assign prdata      = cfg_sel_len ? window_length_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= wrc_pkg::WINDOW_LENGTH_RESET;
        end else if (cfg_write && cfg_sel_len) begin
            window_length_reg <= pwdata;
        end
    end

    logic [W-1:0] win_len;
    assign win_len = (window_length_reg == '0) ? W'(1) : window_length_reg;

    // sequencer and state
    wrc_pkg::state_t state_reg, state_next;

    logic          started_reg, started_next;
    logic [W:0]    next_boundary_reg, next_boundary_next;
    logic [W-1:0]  request_total_reg, request_total_next;
    logic [BW-1:0] byte_total_reg, byte_total_next;
    logic [W-1:0]  object_total_reg, object_total_next;
    logic [W-1:0]  cold_miss_total_reg, cold_miss_total_next;

    logic [W-1:0]  ts_reg, size_reg;
    logic          first_reg, cold_reg;

    logic          out_valid_reg, out_valid_next;
    logic [W-1:0]  out_requests_reg, out_objects_reg, out_cold_reg, out_empties_reg;
    logic [BW-1:0] out_bytes_reg;

    logic          in_beat;
    logic          closes;
    logic          advance;
    logic          div_start;
    logic [W-1:0]  gap;
    logic [BW:0]   byte_sum;

    wrc_pkg::div_status_t div_st;
    logic [W-1:0]  div_quo;
    logic [W-1:0]  div_rem;

    assign s_ready  = state_reg == wrc_pkg::ST_IDLE;
    assign in_beat  = s_valid && s_ready;
    assign closes   = started_reg && ({1'b0, ts_reg} >= next_boundary_reg);
    assign gap      = ts_reg - next_boundary_reg[W-1:0];
    assign byte_sum = {1'b0, byte_total_reg} + {{(BW-W+1){1'b0}}, size_reg};
    assign advance  = (state_reg == wrc_pkg::ST_FINISH) && (!out_valid_reg || m_ready);
    assign div_start = (state_reg == wrc_pkg::ST_ACCUM) && closes;

    wrc_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (gap),
        .divisor   (win_len),
        .status    (div_st),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        state_next           = state_reg;
        started_next         = started_reg;
        next_boundary_next   = next_boundary_reg;
        request_total_next   = request_total_reg;
        byte_total_next      = byte_total_reg;
        object_total_next    = object_total_reg;
        cold_miss_total_next = cold_miss_total_reg;
        out_valid_next       = out_valid_reg && !m_ready;

        unique case (state_reg)
            wrc_pkg::ST_IDLE: begin
                if (in_beat) begin
                    state_next = wrc_pkg::ST_ACCUM;
                end
            end
            wrc_pkg::ST_ACCUM: begin
                if (!started_reg) begin
                    started_next       = 1'b1;
                    next_boundary_next = {1'b0, ts_reg} + {1'b0, win_len};
                end
                request_total_next = (request_total_reg == '1) ?
                                     request_total_reg : request_total_reg + W'(1);
                byte_total_next    = byte_sum[BW] ? '1 : byte_sum[BW-1:0];
                if (first_reg && object_total_reg != '1) begin
                    object_total_next = object_total_reg + W'(1);
                end
                if (cold_reg && cold_miss_total_reg != '1) begin
                    cold_miss_total_next = cold_miss_total_reg + W'(1);
                end
                state_next = closes ? wrc_pkg::ST_DIV : wrc_pkg::ST_IDLE;
            end
            wrc_pkg::ST_DIV: begin
                if (div_st.done) begin
                    state_next = wrc_pkg::ST_FINISH;
                end
            end
            wrc_pkg::ST_FINISH: begin
                // hold until the result slot is free
                if (advance) begin
                    out_valid_next       = 1'b1;
                    request_total_next   = '0;
                    byte_total_next      = '0;
                    object_total_next    = '0;
                    cold_miss_total_next = '0;
                    next_boundary_next   = {1'b0, ts_reg} - {1'b0, div_rem}
                                         + {1'b0, win_len};
                    state_next           = wrc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= wrc_pkg::ST_IDLE;
            started_reg         <= 1'b0;
            next_boundary_reg   <= '0;
            request_total_reg   <= '0;
            byte_total_reg      <= '0;
            object_total_reg    <= '0;
            cold_miss_total_reg <= '0;
            out_valid_reg       <= 1'b0;
        end else begin
            state_reg           <= state_next;
            started_reg         <= started_next;
            next_boundary_reg   <= next_boundary_next;
            request_total_reg   <= request_total_next;
            byte_total_reg      <= byte_total_next;
            object_total_reg    <= object_total_next;
            cold_miss_total_reg <= cold_miss_total_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            ts_reg    <= s_timestamp;
            size_reg  <= s_object_size;
            first_reg <= s_first_in_window;
            cold_reg  <= s_compulsory_miss;
        end
        if (advance) begin
            out_requests_reg <= request_total_reg;
            out_bytes_reg    <= byte_total_reg;
            out_objects_reg  <= object_total_reg;
            out_cold_reg     <= cold_miss_total_reg;
            out_empties_reg  <= div_quo;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_window_requests     = out_requests_reg;
    assign m_window_bytes        = out_bytes_reg;
    assign m_window_objects      = out_objects_reg;
    assign m_window_cold_misses  = out_cold_reg;
    assign m_empty_windows_after = out_empties_reg;

    a_beat_to_accum: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> state_reg == wrc_pkg::ST_ACCUM)
        else $error("accepted request did not enter accumulation");

    a_started_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |=> started_reg)
        else $error("started flag dropped without reset");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg) == wrc_pkg::ST_FINISH)
        else $error("result raised outside the finish step");

    a_boundary_past_request: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> next_boundary_reg > {1'b0, ts_reg})
        else $error("boundary not moved past the closing request");

    a_remainder_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wrc_pkg::ST_FINISH) |-> div_rem < win_len)
        else $error("divider remainder not below window length");

    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wrc_pkg::ST_DIV && !div_st.done) |-> div_st.busy)
        else $error("divider idle while a division is pending");

endmodule

`default_nettype wire

FILE: dv/windowed_request_rate_counter_top_tb.sv
// Testbench for the windowed request rate counter: directed and random request streams checked per window.
module windowed_request_rate_counter_top_tb;

    localparam int unsigned ADDR_W = wrc_pkg::ADDR_W;
    localparam int unsigned DATA_W = wrc_pkg::DATA_W;
    localparam int unsigned BYTE_W = wrc_pkg::BYTE_W;

    localparam logic [ADDR_W-1:0] WINDOW_LENGTH_ADDR =
        ADDR_W'({wrc_pkg::REG_WINDOW_LENGTH, 2'b00});
    localparam int unsigned ITEMS_PER_PHASE = 300;
    localparam int unsigned FINAL_ITEMS = 80;
    localparam int unsigned SETTLE_CYCLES = 50;

    typedef struct packed {
        logic [DATA_W-1:0] requests;
        logic [BYTE_W-1:0] bytes;
        logic [DATA_W-1:0] objects;
        logic [DATA_W-1:0] cold_misses;
        logic [DATA_W-1:0] empties;
    } window_report_t;

    class window_scoreboard;
        bit [31:0]      window_len;
        bit             started;
        bit [32:0]      boundary;
        bit [31:0]      req_total;
        bit [63:0]      byte_total;
        bit [31:0]      obj_total;
        bit [31:0]      cold_total;
        window_report_t closed_q[$];
        int unsigned    requests_seen;
        int unsigned    windows_closed;
        int unsigned    mismatches;

        function new();
            window_len = wrc_pkg::WINDOW_LENGTH_RESET;
            started = 1'b0;
            boundary = '0;
            req_total = '0;
            byte_total = '0;
            obj_total = '0;
            cold_total = '0;
            requests_seen = 0;
            windows_closed = 0;
            mismatches = 0;
        endfunction

        function void report(string msg);
            if (mismatches < 10)
                $display("mismatch: %s", msg);
            mismatches++;
        endfunction

        function string describe(window_report_t t);
            return $sformatf("req=%0d bytes=%0d obj=%0d cold=%0d empty=%0d",
                             t.requests, t.bytes, t.objects, t.cold_misses, t.empties);
        endfunction

        function void set_window_length(bit [31:0] v);
            window_len = v;
        endfunction

        // Accumulate first, then close the window if the request reached the boundary.
        function void note_request(bit [31:0] ts, bit [31:0] size, bit first, bit cold);
            bit [63:0]      w;
            bit [63:0]      gap;
            bit [63:0]      empties;
            bit [63:0]      nb;
            bit [64:0]      sum;
            window_report_t want;
            w = (window_len == 0) ? 64'd1 : 64'(window_len);
            requests_seen++;
            if (!started) begin
                nb = 64'(ts) + w;
                boundary = nb[32:0];
                started = 1'b1;
            end
            if (req_total != '1)
                req_total++;
            sum = 65'(byte_total) + 65'(size);
            byte_total = sum[64] ? '1 : sum[63:0];
            if (first && obj_total != '1)
                obj_total++;
            if (cold && cold_total != '1)
                cold_total++;
            if ({1'b0, ts} < boundary)
                return;
            gap = 64'(ts) - 64'(boundary);
            empties = gap / w;
            want.requests = req_total;
            want.bytes = byte_total;
            want.objects = obj_total;
            want.cold_misses = cold_total;
            want.empties = (empties > 64'hFFFF_FFFF) ? '1 : empties[31:0];
            closed_q.insert(closed_q.size(), want);
            windows_closed++;
            req_total = '0;
            byte_total = '0;
            obj_total = '0;
            cold_total = '0;
            // advance to the first window end past the request
            nb = 64'(boundary) + (empties + 1) * w;
            boundary = nb[32:0];
        endfunction

        function void check_window(window_report_t got);
            window_report_t want;
            if (closed_q.size() == 0) begin
                report($sformatf("unexpected window beat: %s", describe(got)));
                return;
            end
            want = closed_q.pop_front();
            if (got.requests !== want.requests || got.bytes !== want.bytes ||
                got.objects !== want.objects || got.cold_misses !== want.cold_misses ||
                got.empties !== want.empties)
                report($sformatf("expected %s, got %s", describe(want), describe(got)));
        endfunction

        function int unsigned outstanding();
            return closed_q.size();
        endfunction

        function void close_out();
            if (closed_q.size() != 0) begin
                report($sformatf("%0d closed windows never reported", closed_q.size()));
                mismatches += closed_q.size() - 1;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [DATA_W-1:0]   s_timestamp = '0;
    logic [DATA_W-1:0]   s_object_size = '0;
    logic                s_first_in_window = 1'b0;
    logic                s_compulsory_miss = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [DATA_W-1:0]   m_window_requests;
    logic [BYTE_W-1:0]   m_window_bytes;
    logic [DATA_W-1:0]   m_window_objects;
    logic [DATA_W-1:0]   m_window_cold_misses;
    logic [DATA_W-1:0]   m_empty_windows_after;

    window_scoreboard sb = new();
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;

    windowed_request_rate_counter_top u_top (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_timestamp           (s_timestamp),
        .s_object_size         (s_object_size),
        .s_first_in_window     (s_first_in_window),
        .s_compulsory_miss     (s_compulsory_miss),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_window_requests     (m_window_requests),
        .m_window_bytes        (m_window_bytes),
        .m_window_objects      (m_window_objects),
        .m_window_cold_misses  (m_window_cold_misses),
        .m_empty_windows_after (m_empty_windows_after)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Result side: randomly hold m_ready low before each beat, with stall-free runs.
    initial begin
        int unsigned    stall;
        window_report_t got;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = recv_steady ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready));
            got.requests = m_window_requests;
            got.bytes = m_window_bytes;
            got.objects = m_window_objects;
            got.cold_misses = m_window_cold_misses;
            got.empties = m_empty_windows_after;
            sb.check_window(got);
            if ($urandom_range(0, 39) == 0)
                recv_steady = !recv_steady;
        end
    end

    task automatic send_request(input bit [31:0] ts, input bit [31:0] size,
                                input bit first, input bit cold);
        int unsigned gap;
        gap = send_steady ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_timestamp <= ts;
        s_object_size <= size;
        s_first_in_window <= first;
        s_compulsory_miss <= cold;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_request(ts, size, first, cold);
        if ($urandom_range(0, 39) == 0)
            send_steady = !send_steady;
    endtask

    // Drop valid and hold until every closed window has been reported.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
    endtask

    task automatic apb_write(input bit [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= WINDOW_LENGTH_ADDR;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(output logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= WINDOW_LENGTH_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_window_length(input bit [31:0] wl);
        logic [31:0] rd;
        wait_drained();
        // a request that closes nothing may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
        apb_write(wl);
        sb.set_window_length(wl);
        apb_read(rd);
        if (rd !== wl)
            sb.report($sformatf("window_length read back %h, wrote %h", rd, wl));
    endtask

    function automatic bit [31:0] pick_size();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return $urandom;
    endfunction

    // Mostly short steps inside a window, with boundary hits, skips and backward steps.
    function automatic bit [31:0] pick_timestamp(bit [31:0] cur, bit [31:0] wl,
                                                 bit [32:0] bound, bit [31:0] ceiling);
        bit [63:0]   w;
        bit [63:0]   nxt;
        bit [63:0]   lim;
        int unsigned sel;
        w = (wl == 0) ? 64'd1 : 64'(wl);
        sel = $urandom_range(0, 99);
        if (sel < 60)
            nxt = 64'(cur) + $urandom_range(0, 32'((w + 3) / 4));
        else if (sel < 80)
            nxt = 64'(cur) + w * $urandom_range(0, 2) + $urandom_range(0, 32'(w - 1));
        else if (sel < 88)
            nxt = 64'(bound);
        else if (sel < 92)
            nxt = (bound == 0) ? 64'd0 : 64'(bound) - 1;
        else if (sel < 96)
            nxt = 64'(cur) + w * $urandom_range(3, 200);
        else begin
            lim = (64'(cur) < w + 100) ? 64'(cur) : w + 100;
            nxt = 64'(cur) - $urandom_range(0, 32'(lim));
        end
        if (nxt > 64'(ceiling))
            nxt = 64'(ceiling);
        return nxt[31:0];
    endfunction

    initial begin
        logic [31:0] rd;
        bit [31:0]   lengths[6];
        bit [31:0]   ts;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        apb_read(rd);
        if (rd !== wrc_pkg::WINDOW_LENGTH_RESET)
            sb.report($sformatf("window_length after reset reads %h", rd));

        // Directed part at the reset length of 60.
        send_request(32'd0, 32'd0, 1'b0, 1'b0);
        send_request(32'd10, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_request(32'd59, 32'd1, 1'b1, 1'b0);
        send_request(32'd60, 32'hFFFF_FFFF, 1'b0, 1'b1);
        send_request(32'd50, 32'd5, 1'b1, 1'b1);
        send_request(32'd0, 32'd0, 1'b0, 1'b0);
        send_request(32'd119, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_request(32'd400, 32'd12345, 1'b0, 1'b0);
        send_request(32'd420, 32'd0, 1'b1, 1'b0);
        send_request(32'd479, 32'hAAAA_AAAA, 1'b0, 1'b1);
        send_request(32'd480, 32'h5555_5555, 1'b1, 1'b0);
        send_request(32'h0010_0000, 32'd7, 1'b1, 1'b1);
        send_request(32'h0010_0000, 32'd9, 1'b0, 1'b0);
        send_request(32'h0010_0040, 32'hFFFF_FFFF, 1'b1, 1'b1);
        ts = 32'h0010_0040;

        // Boundary carries over each length change; zero acts as one.
        lengths = '{32'd1, 32'd0, 32'd7, 32'd1000, 32'($urandom_range(2, 5000)), 32'd60};
        foreach (lengths[p]) begin
            set_window_length(lengths[p]);
            for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (p == 3 && i == ITEMS_PER_PHASE / 2)
                    wait_drained();
                ts = pick_timestamp(ts, lengths[p], sb.boundary, 32'hF000_0000);
                send_request(ts, pick_size(), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
            end
        end

        // Maximum length goes last: after one more close the boundary leaves the
        // 32-bit timestamp range for good.
        set_window_length(32'hFFFF_FFFF);
        for (int unsigned i = 0; i < FINAL_ITEMS; i++) begin
            ts = pick_timestamp(ts, 32'hFFFF_FFFF, sb.boundary, 32'hFFFF_FFFF);
            send_request(ts, pick_size(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        sb.close_out();
        $display("Run sent %0d requests and checked %0d closed windows", sb.requests_seen,
                 sb.windows_closed);
        $display("Window lengths swept: reset value, 0, 1, 7, 1000, random, 60, all ones");
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/wrc_pkg.sv
rtl/wrc_divider.sv
rtl/windowed_request_rate_counter_top.sv
dv/windowed_request_rate_counter_top_tb.sv
